// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes and item layouts for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT      = 2'd0,
    CMD_SET_STOP = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;

  localparam logic [3:0] FG_RESET = 4'h7;
  localparam logic [3:0] BG_RESET = 4'h0;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic       pad;
    logic       scrolled;
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
    logic [10:0] stop_position;
    logic [10:0] cursor_position;
  } result_t;

endpackage

// ===== hdl/tcw_cfg.sv =====
// ----------------------------------------------------------------------------
// tcw_cfg
// Configuration registers: foreground and background color.
// ----------------------------------------------------------------------------
module tcw_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  attr
);

  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= tcw_pkg::FG_RESET;
      bg_color <= tcw_pkg::BG_RESET;
    end else if (wr_en) begin
      if (paddr[2] == tcw_pkg::REG_FG) begin
        fg_color <= pwdata[3:0];
      end else begin
        bg_color <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == tcw_pkg::REG_FG) begin
      prdata = {28'd0, fg_color};
    end else begin
      prdata = {28'd0, bg_color};
    end
  end

  // Background in the high nibble.
  assign attr = {bg_color, fg_color};

endmodule

// ===== hdl/tcw_screen_mem.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    rdata <= cells[raddr];
  end

endmodule

// ===== hdl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor, column and stop registers, memory sweeps for
// clear and scroll, and the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4,
  localparam int CELL_COUNT = COLUMNS * ROWS,
  localparam int AW = $clog2(CELL_COUNT)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [7:0]                     attr,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [tcw_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [15:0]                    mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [15:0]                    mem_rdata
);

  localparam int CW   = $clog2(CELL_COUNT + TAB_STEP);
  localparam int CNTW = $clog2(CELL_COUNT + 1);
  localparam int COLW = $clog2(COLUMNS);
  localparam int SUMW = COLW + 5;
  localparam int COPY_N = CELL_COUNT - COLUMNS;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  state_t            state;
  tcw_pkg::cmd_t     cmd;
  logic [7:0]        chr;
  logic [10:0]       pos;
  logic [CW-1:0]     cursor;
  logic [COLW-1:0]   col;
  logic [AW-1:0]     stop;
  logic [CNTW-1:0]   cnt;
  logic [15:0]       fill;
  logic              sweep_reply;
  logic              rd_ok;
  logic [15:0]       rd_cell;
  logic              scrolled;

  logic [15:0]       blank;
  logic [SUMW-1:0]   col_sum;
  logic [SUMW-1:0]   col_red;
  logic [SUMW-1:0]   col_tab;
  logic [CW-1:0]     put_cursor;
  logic [COLW-1:0]   put_col;
  logic              put_we;
  logic [CW-1:0]     put_waddr;
  logic [15:0]       put_wdata;
  logic [CW-1:0]     cur_up;
  logic [AW-1:0]     stop_up;
  logic              pos_ok;
  tcw_pkg::result_t  result;

  assign s_tready = (state == ST_IDLE);
  assign blank    = {attr, 8'h00};
  assign pos_ok   = 32'(pos) < 32'(CELL_COUNT);
  assign cur_up   = cursor - CW'(COLUMNS);
  assign stop_up  = (stop >= AW'(COLUMNS)) ? stop - AW'(COLUMNS) : '0;

  // Column after a tab: at most two wraps for the narrowest screen.
  always_comb begin
    col_sum = SUMW'(col) + SUMW'(TAB_STEP);
    col_red = (col_sum >= SUMW'(COLUMNS)) ? col_sum - SUMW'(COLUMNS) : col_sum;
    col_tab = (col_red >= SUMW'(COLUMNS)) ? col_red - SUMW'(COLUMNS) : col_red;
  end

  always_comb begin
    put_cursor = cursor;
    put_col    = col;
    put_we     = 1'b0;
    put_waddr  = cursor;
    put_wdata  = {attr, chr};
    case (chr)
      tcw_pkg::CH_BACKSPACE: begin
        if (cursor > CW'(stop)) begin
          put_cursor = cursor - CW'(1);
          put_col    = (col == '0) ? COLW'(COLUMNS - 1) : col - COLW'(1);
          put_we     = 1'b1;
          put_waddr  = cursor - CW'(1);
          put_wdata  = blank;
        end
      end
      tcw_pkg::CH_TAB: begin
        put_cursor = cursor + CW'(TAB_STEP);
        put_col    = COLW'(col_tab);
      end
      tcw_pkg::CH_NEWLINE: begin
        put_cursor = cursor + CW'(COLUMNS) - CW'(col);
        put_col    = '0;
      end
      default: begin
        put_cursor = cursor + CW'(1);
        put_col    = (col == COLW'(COLUMNS - 1)) ? '0 : col + COLW'(1);
        put_we     = 1'b1;
      end
    endcase
  end

  // Memory port steering.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt);
        mem_wdata = fill;
      end
      ST_EXEC: begin
        if (cmd == tcw_pkg::CMD_PUT) begin
          mem_we    = put_we;
          mem_waddr = AW'(put_waddr);
          mem_wdata = put_wdata;
        end else if (cmd == tcw_pkg::CMD_READ) begin
          mem_raddr = AW'(pos);
        end
      end
      ST_SCROLL: begin
        // Read one row ahead; write in the cycle after the read.
        if (cnt < CNTW'(COPY_N)) begin
          mem_raddr = AW'(cnt + CNTW'(COLUMNS));
        end
        if (cnt != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt - CNTW'(1));
          mem_wdata = (cnt <= CNTW'(COPY_N)) ? mem_rdata : blank;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result                 = '0;
    result.cursor_position = 11'(cursor);
    result.stop_position   = 11'(stop);
    result.cell_char       = rd_cell[7:0];
    result.cell_attr       = rd_cell[15:8];
    result.scrolled        = scrolled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      cnt         <= '0;
      fill        <= '0;
      sweep_reply <= 1'b0;
      cursor      <= '0;
      col         <= '0;
      stop        <= '0;
      scrolled    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          if (cnt == CNTW'(CELL_COUNT - 1)) begin
            cnt   <= '0;
            state <= sweep_reply ? ST_DONE : ST_IDLE;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd      <= tcw_pkg::cmd_t'(s_tuser);
            chr      <= s_tdata[7:0];
            pos      <= s_tdata[18:8];
            scrolled <= 1'b0;
            rd_cell  <= '0;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd)
            tcw_pkg::CMD_PUT: begin
              cursor <= put_cursor;
              col    <= put_col;
              cnt    <= '0;
              state  <= (put_cursor >= CW'(CELL_COUNT)) ? ST_SCROLL : ST_DONE;
            end
            tcw_pkg::CMD_SET_STOP: begin
              stop  <= pos_ok ? AW'(pos) : AW'(CELL_COUNT - 1);
              state <= ST_DONE;
            end
            tcw_pkg::CMD_CLEAR: begin
              fill        <= blank;
              cnt         <= '0;
              sweep_reply <= 1'b1;
              cursor      <= '0;
              col         <= '0;
              stop        <= '0;
              state       <= ST_SWEEP;
            end
            tcw_pkg::CMD_READ: begin
              rd_ok <= pos_ok;
              state <= ST_RD_WAIT;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_RD_WAIT: begin
          rd_cell <= rd_ok ? mem_rdata : '0;
          state   <= ST_DONE;
        end
        ST_SCROLL: begin
          if (cnt == CNTW'(CELL_COUNT)) begin
            cnt      <= '0;
            cursor   <= cur_up;
            stop     <= stop_up;
            scrolled <= 1'b1;
            state    <= (cur_up >= CW'(CELL_COUNT)) ? ST_SCROLL : ST_DONE;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        ST_DONE: begin
          // Hold until the result register is free.
          if (!m_tvalid || m_tready) begin
            m_tdata     <= result;
            m_tvalid    <= 1'b1;
            sweep_reply <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with cursor, backspace stop and scrolling.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: the command in s_axis_tuser,
// char_code and position in s_axis_tdata. Each item gives exactly one result
// item on m_axis: cursor, stop, the cell read (zero for other commands) and
// a scroll flag. Colors are set through the APB port; the user must do so only
// while the block is idle, as the block does not enforce it. One item is in
// work at a time; the next is taken once the result is in the output register,
// so a stalled receiver holds at most one result. Work per item, from accept
// to result valid: put and set stop execute, then give the result; read cell
// executes, waits for the memory read, then gives the result; a put that
// scrolls sweeps every cell per row scrolled, the screen memory copied one cell
// per cycle through its single write port; clear screen writes one cell per
// cycle. After reset a clearing pass zeroes the screen; s_axis_tready stays
// low until it ends. Config writes are taken always.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] char_code, [18:8] position, [23:19] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] cursor_position, [21:11] stop_position, [29:22] cell_char,
  // [37:30] cell_attr, [38] scrolled, [39] zero
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);

  logic [7:0]    attr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  tcw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  tcw_screen_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_ctrl #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== hdl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Reset starts the clearing pass with no result pending.
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("input open or result pending after reset");

  // One item in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Cursor and stop stay on the screen after every item.
  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(m_axis_tdata[10:0]) < 32'(CELL_COUNT)) &&
                      (32'(m_axis_tdata[21:11]) < 32'(CELL_COUNT)))
    else $error("cursor or stop beyond the cell count");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

// ===== sim/console_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_checker
// Watches the item channels and the APB port of the text console writer. It
// keeps its own screen, cursor, backspace stop and colors, works out the
// status item that each accepted command must give, and compares every status
// item on m_axis with the oldest one due.
// ----------------------------------------------------------------------------
module console_checker #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [7:0] char_code, [18:8] position, [23:19] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] cursor_position, [21:11] stop_position, [29:22] cell_char,
  // [37:30] cell_attr, [38] scrolled, [39] zero
  input  logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          status_count,
  output int          scroll_count
);

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 40;

  logic [15:0]      screen [CELLS];
  int               cursor;
  int               back_stop;
  logic [3:0]       fg;
  logic [3:0]       bg;
  tcw_pkg::result_t status_due [$];
  int               fails = 0;
  int               status_total = 0;
  int               scroll_total = 0;

  // Apply one command to the screen copy and return the status it gives.
  function automatic tcw_pkg::result_t step_console(tcw_pkg::cmd_t cmd, logic [7:0] ch,
                                                    logic [10:0] pos);
    tcw_pkg::result_t r;
    int i;
    r = '0;
    case (cmd)
      tcw_pkg::CMD_PUT: begin
        if (ch == tcw_pkg::CH_BACKSPACE) begin
          if (cursor > back_stop) begin
            cursor--;
            if (cursor < CELLS) screen[cursor] = {bg, fg, 8'h00};
          end
        end else if (ch == tcw_pkg::CH_TAB) begin
          cursor += TAB_STEP;
        end else if (ch == tcw_pkg::CH_NEWLINE) begin
          cursor += COLUMNS - cursor % COLUMNS;
        end else begin
          if (cursor < CELLS) screen[cursor] = {bg, fg, ch};
          cursor++;
        end
        // move rows up and blank the last one
        while (cursor >= CELLS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {bg, fg, 8'h00};
          cursor -= COLUMNS;
          back_stop = (back_stop >= COLUMNS) ? back_stop - COLUMNS : 0;
          r.scrolled = 1'b1;
        end
      end
      tcw_pkg::CMD_SET_STOP: begin
        back_stop = (pos < CELLS) ? int'(pos) : CELLS - 1;
      end
      tcw_pkg::CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {bg, fg, 8'h00};
        cursor    = 0;
        back_stop = 0;
      end
      default: begin
        if (pos < CELLS) begin
          r.cell_char = screen[pos][7:0];
          r.cell_attr = screen[pos][15:8];
        end
      end
    endcase
    r.cursor_position = cursor[10:0];
    r.stop_position   = back_stop[10:0];
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    tcw_pkg::result_t seen;
    tcw_pkg::result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < CELLS; i++) screen[i] = '0;
      cursor    = 0;
      back_stop = 0;
      fg        = tcw_pkg::FG_RESET;
      bg        = tcw_pkg::BG_RESET;
      status_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        status_total++;
        if (status_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: status item with nothing due, expected none, got %h",
                     $time, seen);
        end else begin
          want = status_due.pop_front();
          check_field("cursor_position", want.cursor_position, seen.cursor_position);
          check_field("stop_position", want.stop_position, seen.stop_position);
          check_field("cell_char", want.cell_char, seen.cell_char);
          check_field("cell_attr", want.cell_attr, seen.cell_attr);
          check_field("scrolled", want.scrolled, seen.scrolled);
          check_field("pad", want.pad, seen.pad);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == tcw_pkg::REG_FG) fg = pwdata[3:0];
        else bg = pwdata[3:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = step_console(tcw_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[7:0],
                            s_axis_tdata[18:8]);
        if (want.scrolled) scroll_total++;
        status_due.push_back(want);
      end
    end
    fail_count   <= fails;
    pending      <= status_due.size();
    status_count <= status_total;
    scroll_count <= scroll_total;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the text console writer with a directed opening and random commands
// under six color settings, with random stalls on both channels, one long
// receiver hold-off and a calm phase; the checker judges every status item.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_STEP    = 4;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 170;
  localparam int IDLE_PCT    = 24;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 8_000_000;

  localparam logic [2:0] ADDR_FG = {tcw_pkg::REG_FG, 2'b00};
  localparam logic [2:0] ADDR_BG = {tcw_pkg::REG_BG, 2'b00};

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int status_count;
  int scroll_count;

  bit calm        = 1'b0;
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int clears_sent = 0;
  int reads_sent  = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_writer_top #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STEP(TAB_STEP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STEP(TAB_STEP)
  ) console_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .status_count (status_count),
    .scroll_count (scroll_count)
  );

  // Receiver: random stalls, none while calm, and one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status items still due", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; valid stays high afterwards.
  task automatic offer(tcw_pkg::cmd_t cmd, logic [7:0] ch, logic [10:0] pos);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'b0, pos, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (cmd == tcw_pkg::CMD_CLEAR) clears_sent++;
    if (cmd == tcw_pkg::CMD_READ) reads_sent++;
  endtask

  // Drop valid and wait until every status item has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [3:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {28'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly puts with many newlines so the screen keeps scrolling.
  task automatic random_item();
    int            p;
    int            q;
    tcw_pkg::cmd_t cmd;
    logic [7:0]    ch;
    logic [10:0]   pos;
    p   = $urandom_range(99);
    q   = $urandom_range(99);
    ch  = 8'($urandom_range(255));
    pos = 11'($urandom_range(2047));
    if ($urandom_range(299) == 0) begin
      cmd = tcw_pkg::CMD_CLEAR;
    end else if (p < 78) begin
      cmd = tcw_pkg::CMD_PUT;
      if (q < 10) ch = tcw_pkg::CH_BACKSPACE;
      else if (q < 17) ch = tcw_pkg::CH_TAB;
      else if (q < 43) ch = tcw_pkg::CH_NEWLINE;
    end else if (p < 84) begin
      cmd = tcw_pkg::CMD_SET_STOP;
      if (q < 50) pos = 11'($urandom_range(2 * COLUMNS - 1));
    end else begin
      cmd = tcw_pkg::CMD_READ;
      if (q < 30) pos = 11'($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
    end
    offer(cmd, ch, pos);
  endtask

  initial begin
    int         k;
    int         ph;
    int         n;
    logic [3:0] fgv;
    logic [3:0] bgv;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset contents and out-of-range read
    offer(tcw_pkg::CMD_READ, 8'h00, 11'd0);
    offer(tcw_pkg::CMD_READ, 8'h00, 11'h7ff);
    // printed bytes at both extremes, then erase one
    offer(tcw_pkg::CMD_PUT, 8'h41, 11'd0);
    offer(tcw_pkg::CMD_PUT, 8'h00, 11'd0);
    offer(tcw_pkg::CMD_PUT, 8'hff, 11'd0);
    offer(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    offer(tcw_pkg::CMD_READ, 8'h00, 11'd2);
    offer(tcw_pkg::CMD_READ, 8'h00, 11'd1);
    offer(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 11'd0);
    // backspace blocked at the stop
    offer(tcw_pkg::CMD_SET_STOP, 8'h00, 11'd6);
    offer(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    // stop saturates past the last cell
    offer(tcw_pkg::CMD_SET_STOP, 8'h00, 11'h7ff);
    offer(tcw_pkg::CMD_SET_STOP, 8'h00, 11'(CELLS));
    offer(tcw_pkg::CMD_SET_STOP, 8'h00, 11'(CELLS - 1));
    // walk down to the last row, then scroll with a high and a low stop
    for (k = 0; k < ROWS - 1; k++) offer(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    offer(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    offer(tcw_pkg::CMD_SET_STOP, 8'h00, 11'd40);
    offer(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    offer(tcw_pkg::CMD_READ, 8'h00, 11'(CELLS - 1));
    offer(tcw_pkg::CMD_READ, 8'h00, 11'd0);
    offer(tcw_pkg::CMD_CLEAR, 8'h00, 11'd0);
    offer(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    offer(tcw_pkg::CMD_READ, 8'h00, 11'd5);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin fgv = 4'hf; bgv = 4'hf; end
        1: begin fgv = 4'h0; bgv = 4'h0; end
        2: begin fgv = 4'hf; bgv = 4'h0; end
        3: begin fgv = 4'h0; bgv = 4'hf; end
        default: begin fgv = 4'($urandom_range(15)); bgv = 4'($urandom_range(15)); end
      endcase
      write_reg(ADDR_FG, fgv);
      write_reg(ADDR_BG, bgv);
      calm <= (ph == 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 30) hold_toggle <= ~hold_toggle;
        random_item();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("Run: %0d commands (%0d clears, %0d reads), %0d status items, %0d scrolls",
             items_sent, clears_sent, reads_sent, status_count, scroll_count);
    $display("Colors swept over %0d settings with both nibbles at 0 and 15", PHASES + 1);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tcw_pkg.sv
hdl/tcw_cfg.sv
hdl/tcw_screen_mem.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer_top.sv
hdl/tcw_checker.sv
sim/console_checker.sv
sim/testbench.sv
